@@ design/wrv_pkg.sv @@
`default_nettype none

package wrv_pkg;

   // default field formats
   localparam int SAMPLE_BITS_DEFAULT        = 16;
   localparam int MEAN_FRACTION_BITS_DEFAULT = 24;

   // fixed formats of the statistics and the result
   localparam int COUNT_BITS    = 32;
   localparam int M_BITS        = 64;
   localparam int VAR_BITS      = 48;
   localparam int VAR_FRAC_BITS = 16;

   // shared radix-2 divider
   localparam int DIV_BITS      = 64;
   localparam int DIVISOR_BITS  = 32;
   localparam int DIV_STEP_BITS = $clog2(DIV_BITS + 1);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MAG,
      ST_DIV_MEAN,
      ST_D2,
      ST_MUL,
      ST_ACC,
      ST_VSTART,
      ST_DIV_VAR,
      ST_OUT
   } state_type;

   // divider command and status
   typedef struct packed {
      logic                     start;
      logic [DIV_STEP_BITS-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ design/wrv_divider.sv @@
`default_nettype none

module wrv_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wrv_pkg::div_cmd_type              div_cmd,
   input  wire logic [wrv_pkg::DIV_BITS-1:0]      dividend,
   input  wire logic [wrv_pkg::DIVISOR_BITS-1:0]  divisor,
   output wrv_pkg::div_status_type                div_status,
   output logic      [wrv_pkg::DIV_BITS-1:0]      quotient
);

   localparam int DivBits = wrv_pkg::DIV_BITS;
   localparam int DvsBits = wrv_pkg::DIVISOR_BITS;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [wrv_pkg::DIV_STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [DvsBits-1:0]                rem_ff, rem_in;
   logic [DivBits-1:0]                dq_ff, dq_in;
   logic [DvsBits-1:0]                dvs_ff, dvs_in;
   logic [DvsBits+1:0]                trial;
   logic                              ge;

   // one restoring step: shift in the next dividend bit and try the divisor
   assign trial = {1'b0, rem_ff, dq_ff[DivBits-1]} - {2'b00, dvs_ff};
   assign ge    = !trial[DvsBits+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = div_cmd.steps;
         rem_in  = '0;
         dq_in   = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DvsBits-1:0] : {rem_ff[DvsBits-2:0], dq_ff[DivBits-1]};
         dq_in  = {dq_ff[DivBits-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // remainder, dividend/quotient shift register, divisor
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;
   assign quotient        = dq_ff;

endmodule

`default_nettype wire

@@ design/welford_running_variance_unit.sv @@
// channel  dir  tdata                        tuser
// req      in   sample (signed)              series_start
// rsp      out  variance (unsigned Q32.16)   variance_valid, saturated
//
// a result is loaded into the output register after its sample runs through each step
// and the sequencer goes back to idle for the next sample; the first sample of a
// series skips the variance divide, and the mean-step divide, deviation multiply
// and 64-step variance divide run one bit a cycle
// reset clears count, mean and sum of squares and empties the output register.
// a new sample is taken while the last result waits; a stalled result holds the next one
`default_nettype none

module welford_running_variance_unit #(
   parameter int SAMPLE_BITS        = wrv_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MEAN_FRACTION_BITS = wrv_pkg::MEAN_FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // sample
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // series_start
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // variance
   output logic      [wrv_pkg::VAR_BITS-1:0]         rsp_tdata,
   // variance_valid, saturated
   output logic      [1:0]                           rsp_tuser
);

   localparam int MW       = SAMPLE_BITS + MEAN_FRACTION_BITS;
   localparam int DW       = MW + 1;
   localparam int PW       = 2 * DW;
   localparam int MBits    = wrv_pkg::M_BITS;
   localparam int EW       = (PW > MBits) ? PW : MBits;
   localparam int PS       = 2 * MEAN_FRACTION_BITS - wrv_pkg::VAR_FRAC_BITS;
   localparam int CBits    = wrv_pkg::COUNT_BITS;
   localparam int VBits    = wrv_pkg::VAR_BITS;
   localparam int DivBits  = wrv_pkg::DIV_BITS;
   localparam int StepBits = wrv_pkg::DIV_STEP_BITS;
   localparam int MulBits  = $clog2(DW + 1);

   wrv_pkg::state_type state_ff, state_in;

   logic [CBits-1:0]   count_ff, count_in;
   logic [MW-1:0]      mean_ff, mean_in;
   logic [MBits-1:0]   m_ff, m_in;
   logic [MW-1:0]      xq_ff, xq_in;
   logic [DW-1:0]      d1_ff, d1_in;
   logic [DW-1:0]      d1_mag_ff, d1_mag_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [MulBits-1:0] mul_cnt_ff, mul_cnt_in;
   logic               sat_ff, sat_in;
   logic               valid_ff, valid_in;
   logic [VBits-1:0]   var_ff, var_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VBits-1:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   wrv_pkg::div_cmd_type    div_cmd;
   wrv_pkg::div_status_type div_status;
   logic [DivBits-1:0]      div_dividend;
   logic [CBits-1:0]        div_divisor;
   logic [DivBits-1:0]      div_quotient;

   logic               accept;
   logic [CBits-1:0]   count_base;
   logic [MW-1:0]      mean_step;
   logic [DW-1:0]      q_mean;
   logic [DW:0]        mul_sum;
   logic [EW-1:0]      prod_ext;
   logic [EW-1:0]      prod_shift;
   logic               prod_over;
   logic [MBits:0]     m_sum;

   assign accept = req_tvalid && req_tready;

   // product scaled to Q.16 and added to the sum of squares
   assign prod_ext   = EW'(prod_ff);
   assign prod_shift = prod_ext >> PS;
   assign prod_over  = (prod_ext >> (PS + MBits)) != '0;
   assign m_sum      = {1'b0, m_ff} + {1'b0, prod_shift[MBits-1:0]};

   // shift-and-add step of the deviation product
   assign mul_sum = {1'b0, prod_ff[PW-1:DW]} + {1'b0, d1_mag_ff};

   // truncated mean step with the sign of the first deviation
   assign q_mean    = div_quotient[DW-1:0];
   assign mean_step = d1_ff[DW-1] ? MW'(~q_mean) : MW'(q_mean);

   // count base after an optional series restart
   assign count_base = req_tuser ? '0 : count_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      m_in         = m_ff;
      xq_in        = xq_ff;
      d1_in        = d1_ff;
      d1_mag_in    = d1_mag_ff;
      prod_in      = prod_ff;
      mul_cnt_in   = mul_cnt_ff;
      sat_in       = sat_ff;
      valid_in     = valid_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_cmd      = '0;
      div_dividend = '0;
      div_divisor  = '0;
      req_tready   = 1'b0;

      case (state_ff)
         wrv_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               xq_in    = {req_tdata[SAMPLE_BITS-1:0], {MEAN_FRACTION_BITS{1'b0}}};
               sat_in   = &count_base;
               count_in = (&count_base) ? count_base : count_base + 1'b1;
               if (req_tuser) begin
                  mean_in = '0;
                  m_in    = '0;
               end
               state_in = wrv_pkg::ST_PREP;
            end
         end
         wrv_pkg::ST_PREP: begin
            d1_in    = {xq_ff[MW-1], xq_ff} - {mean_ff[MW-1], mean_ff};
            state_in = wrv_pkg::ST_MAG;
         end
         wrv_pkg::ST_MAG: begin
            d1_mag_in     = d1_ff[DW-1] ? (~d1_ff + 1'b1) : d1_ff;
            div_cmd.start = 1'b1;
            div_cmd.steps = StepBits'(DW);
            div_dividend  = {d1_mag_in, {(DivBits-DW){1'b0}}};
            div_divisor   = count_ff;
            state_in      = wrv_pkg::ST_DIV_MEAN;
         end
         wrv_pkg::ST_DIV_MEAN: begin
            if (div_status.done) begin
               mean_in  = mean_ff + mean_step + MW'(d1_ff[DW-1]);
               state_in = wrv_pkg::ST_D2;
            end
         end
         wrv_pkg::ST_D2: begin
            // the second deviation keeps the sign of the first
            if (d1_ff[DW-1]) begin
               prod_in = {{DW{1'b0}}, {mean_ff[MW-1], mean_ff} - {xq_ff[MW-1], xq_ff}};
            end else begin
               prod_in = {{DW{1'b0}}, {xq_ff[MW-1], xq_ff} - {mean_ff[MW-1], mean_ff}};
            end
            mul_cnt_in = MulBits'(DW);
            state_in   = wrv_pkg::ST_MUL;
         end
         wrv_pkg::ST_MUL: begin
            if (prod_ff[0]) begin
               prod_in = {mul_sum, prod_ff[DW-1:1]};
            end else begin
               prod_in = {1'b0, prod_ff[PW-1:1]};
            end
            mul_cnt_in = mul_cnt_ff - 1'b1;
            if (mul_cnt_ff == 1) begin
               state_in = wrv_pkg::ST_ACC;
            end
         end
         wrv_pkg::ST_ACC: begin
            m_in     = (prod_over || m_sum[MBits]) ? '1 : m_sum[MBits-1:0];
            state_in = wrv_pkg::ST_VSTART;
         end
         wrv_pkg::ST_VSTART: begin
            sat_in = sat_ff | (&m_ff);
            if (count_ff != 1) begin
               valid_in      = 1'b1;
               div_cmd.start = 1'b1;
               div_cmd.steps = StepBits'(DivBits);
               div_dividend  = m_ff;
               div_divisor   = count_ff - 1'b1;
               state_in      = wrv_pkg::ST_DIV_VAR;
            end else begin
               valid_in = 1'b0;
               var_in   = '0;
               state_in = wrv_pkg::ST_OUT;
            end
         end
         wrv_pkg::ST_DIV_VAR: begin
            if (div_status.done) begin
               if (|div_quotient[DivBits-1:VBits]) begin
                  var_in = '1;
                  sat_in = 1'b1;
               end else begin
                  var_in = div_quotient[VBits-1:0];
               end
               state_in = wrv_pkg::ST_OUT;
            end
         end
         wrv_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = var_ff;
               rsp_user_in  = {sat_ff, valid_ff};
               state_in     = wrv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrv_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // statistics and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mean_ff      <= '0;
         m_ff         <= '0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         m_ff         <= m_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      xq_ff       <= xq_in;
      d1_ff       <= d1_in;
      d1_mag_ff   <= d1_mag_in;
      prod_ff     <= prod_in;
      sat_ff      <= sat_in;
      valid_ff    <= valid_in;
      var_ff      <= var_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   wrv_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_cmd    (div_cmd),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .div_status (div_status),
      .quotient   (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // divider is never left running while the sequencer waits for a sample
   assert property (@(posedge clock) disable iff (reset)
      state_ff == wrv_pkg::ST_IDLE |-> !div_status.busy)
      else $error("divider busy while idle");

   // the first sample of a series carries a zero variance
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("variance not zero on first sample");

   // a series restart leaves a count of one
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> count_ff == 1)
      else $error("count not one after series start");

   // multiply never runs with an exhausted bit counter
   assert property (@(posedge clock) disable iff (reset)
      state_ff == wrv_pkg::ST_MUL |-> mul_cnt_ff != 0)
      else $error("multiply counter underflow");
`endif

endmodule

`default_nettype wire

@@ bench/tb_welford_running_variance_unit.sv @@
module tb_welford_running_variance_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = wrv_pkg::SAMPLE_BITS_DEFAULT;
   localparam int MEAN_FRAC     = wrv_pkg::MEAN_FRACTION_BITS_DEFAULT;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PROD_SHIFT    = 2 * MEAN_FRAC - wrv_pkg::VAR_FRAC_BITS;
   localparam logic [63:0] VARIANCE_FULL_SCALE = (64'd1 << wrv_pkg::VAR_BITS) - 64'd1;
   localparam logic [wrv_pkg::COUNT_BITS-1:0] COUNT_LIMIT = '1;
   localparam logic [63:0] SUM_LIMIT = '1;

   localparam int IDLE_PERCENT         = 13;
   localparam int RECEIVER_HOLD_CYCLES = 3000;
   localparam int WATCHDOG_LIMIT       = 20000;
   localparam int DRAIN_TAIL_CYCLES    = 400;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   series_start;
   } sample_item_type;

   typedef struct packed {
      logic [wrv_pkg::VAR_BITS-1:0] variance;
      logic                         variance_valid;
      logic                         saturated;
   } variance_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_BITS-1:0]     req_tdata  = '0;   // sample
   logic                         req_tuser  = 1'b0; // series_start
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [wrv_pkg::VAR_BITS-1:0] rsp_tdata;         // variance
   logic [1:0]                   rsp_tuser;         // variance_valid, saturated

   // predictor copy of the running statistics
   logic [wrv_pkg::COUNT_BITS-1:0] stat_count = '0;
   logic signed [63:0]             stat_mean  = '0;
   logic [63:0]                    stat_m2    = '0;

   sample_item_type     pending_samples[$];
   variance_result_type predicted_variances[$];

   logic req_fired   = 1'b0;
   logic idle_enable = 1'b1;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   int   samples_queued   = 0;
   int   samples_accepted = 0;
   int   results_checked  = 0;
   int   series_count     = 0;
   int   mismatch_count   = 0;

   welford_running_variance_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // one welford step on the predictor state, giving the expected result
   function automatic variance_result_type welford_update(
      input logic signed [SAMPLE_BITS-1:0] x, input logic start);
      logic signed [63:0]  xq;
      logic signed [63:0]  d1;
      logic signed [63:0]  d2;
      logic [63:0]         mag1;
      logic [63:0]         mag2;
      logic [63:0]         mean_step;
      logic [63:0]         n;
      logic [63:0]         var_full;
      logic [127:0]        product;
      logic                sat;
      variance_result_type r;
      sat = 1'b0;
      if (start) begin
         stat_count = '0;
         stat_mean  = '0;
         stat_m2    = '0;
      end
      // count sticks at its limit
      if (stat_count == COUNT_LIMIT) sat = 1'b1;
      else stat_count = stat_count + 1'b1;
      n = {32'd0, stat_count};
      xq = x;
      xq = xq <<< MEAN_FRAC;
      // mean step truncated toward zero
      d1 = xq - stat_mean;
      mag1 = d1[63] ? -d1 : d1;
      mean_step = mag1 / n;
      stat_mean = d1[63] ? stat_mean - mean_step : stat_mean + mean_step;
      d2 = xq - stat_mean;
      mag2 = d2[63] ? -d2 : d2;
      // exact product brought down to q.16, sum held at its limit on overflow
      product = {64'd0, mag1} * {64'd0, mag2};
      product = product >> PROD_SHIFT;
      if (product[127:64] != '0 || stat_m2 > SUM_LIMIT - product[63:0]) stat_m2 = SUM_LIMIT;
      else stat_m2 = stat_m2 + product[63:0];
      if (stat_m2 == SUM_LIMIT) sat = 1'b1;
      // unbiased variance, clipped at full scale
      var_full = '0;
      r.variance_valid = (n > 64'd1);
      if (r.variance_valid) begin
         var_full = stat_m2 / (n - 64'd1);
         if (var_full > VARIANCE_FULL_SCALE) begin
            var_full = VARIANCE_FULL_SCALE;
            sat = 1'b1;
         end
      end
      r.variance  = var_full[wrv_pkg::VAR_BITS-1:0];
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic start);
      sample_item_type item;
      item.sample       = x;
      item.series_start = start;
      pending_samples.push_back(item);
      samples_queued++;
      if (start) series_count++;
   endtask

   // series of random length and content, with a little noise mixed in
   task automatic queue_random_items(input int target);
      int added;
      int length;
      int kind;
      logic [SAMPLE_BITS-1:0] base;
      logic [SAMPLE_BITS-1:0] x;
      logic start;
      added = 0;
      while (added < target) begin
         if ($urandom_range(99) < 3) length = $urandom_range(400, 150);
         else if ($urandom_range(99) < 10) length = 1;
         else length = $urandom_range(30, 2);
         kind = $urandom_range(3);
         base = SAMPLE_BITS'($urandom);
         for (int i = 0; i < length; i++) begin
            case (kind)
               0: begin
                  x = SAMPLE_BITS'($urandom);
               end
               1: begin
                  case ($urandom_range(3))
                     0: x = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                     1: x = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                     2: x = '0;
                     default: x = '1;
                  endcase
               end
               2: begin
                  x = base + SAMPLE_BITS'($urandom_range(31));
               end
               default: begin
                  x = base;
               end
            endcase
            // head of series mostly flagged, stray restarts now and then
            if (i == 0) start = ($urandom_range(99) < 92);
            else start = ($urandom_range(99) < 2);
            queue_sample(x, start);
            added++;
         end
      end
   endtask

   task automatic wait_for_drain;
      while (samples_accepted != samples_queued || predicted_variances.size() != 0)
         @(posedge clock);
   endtask

   // sample driver
   always @(negedge clock) begin : sample_driver
      sample_item_type item;
      logic            next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid && !req_fired;
         if (!next_valid && pending_samples.size() != 0
             && !(idle_enable && $urandom_range(99) < IDLE_PERCENT)) begin
            item = pending_samples.pop_front();
            req_tdata  <= REQ_DATA_BITS'(item.sample);
            req_tuser  <= item.series_start;
            next_valid = 1'b1;
         end
         req_tvalid <= next_valid;
      end
   end

   // result receiver, with an occasional long hold-off
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = RECEIVER_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // monitor: predict on each accepted sample, check each accepted result
   always @(posedge clock) begin : channel_monitor
      variance_result_type expected;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predicted_variances.push_back(
               welford_update(req_tdata[SAMPLE_BITS-1:0], req_tuser));
            samples_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (predicted_variances.size() == 0) begin
               report_mismatch($sformatf("unexpected result variance=%h tuser=%b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               expected = predicted_variances.pop_front();
               if (rsp_tdata !== expected.variance)
                  report_mismatch($sformatf("result %0d variance %h, expected %h",
                                            results_checked, rsp_tdata, expected.variance));
               if (rsp_tuser[0] !== expected.variance_valid)
                  report_mismatch($sformatf("result %0d variance_valid %b, expected %b",
                                            results_checked, rsp_tuser[0],
                                            expected.variance_valid));
               if (rsp_tuser[1] !== expected.saturated)
                  report_mismatch($sformatf("result %0d saturated %b, expected %b",
                                            results_checked, rsp_tuser[1],
                                            expected.saturated));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // stimulus phases
   initial begin : stimulus
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: sample with no series flag straight after reset
      queue_sample(16'sd12345, 1'b0);
      // widest swing between the extremes
      queue_sample(-16'sd32768, 1'b1);
      queue_sample(16'sd32767, 1'b0);
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(16'sd32767, 1'b0);
      // single-sample series back to back, variance undefined each time
      queue_sample(16'sd32767, 1'b1);
      queue_sample(-16'sd1, 1'b1);
      // constant series gives zero variance
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sd0, 1'b0);
      queue_sample(16'sd0, 1'b0);
      // small alternating values
      queue_sample(16'sd1, 1'b1);
      queue_sample(-16'sd1, 1'b0);
      queue_sample(16'sd1, 1'b0);
      queue_sample(-16'sd1, 1'b0);
      queue_sample(16'sd0, 1'b0);
      // near the negative end
      queue_sample(-16'sd32768, 1'b1);
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(-16'sd32767, 1'b0);
      // alternating bit patterns, then a value just below the positive end
      queue_sample(16'sh5555, 1'b1);
      queue_sample(16'shAAAA, 1'b0);
      queue_sample(16'sh7FFE, 1'b0);
      // sender pause until every result is back
      wait_for_drain();

      queue_random_items(400);
      // long receiver hold while the sender keeps offering
      hold_requests++;
      queue_random_items(300);
      while (pending_samples.size() != 0) @(posedge clock);

      // stretch with no idling on either side
      idle_enable = 1'b0;
      queue_random_items(300);
      while (pending_samples.size() != 0) @(posedge clock);
      idle_enable = 1'b1;
      wait_for_drain();

      queue_random_items(700);
      wait_for_drain();
      repeat (DRAIN_TAIL_CYCLES) @(posedge clock);

      if (predicted_variances.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", predicted_variances.size()));
      $display("run covered %0d samples in %0d flagged series, %0d results checked",
               samples_accepted, series_count, results_checked);
      $display("with a long output stall, drain pauses and a stretch without idling");
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/wrv_pkg.sv
design/wrv_divider.sv
design/welford_running_variance_unit.sv
bench/tb_welford_running_variance_unit.sv
